FILE: src/lamp_priority_flasher_assert.svh
// assertion macros shared by the lamp flasher checker
`ifndef LAMP_PRIORITY_FLASHER_ASSERT_SVH
`define LAMP_PRIORITY_FLASHER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define LPF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lamp flasher check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define LPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lamp flasher check failed");

`endif

FILE: src/lpf_pkg.sv
// types, codes and constants of the lamp priority flasher
`timescale 1ns / 1ps
package lpf_pkg;

   // event kinds
   localparam logic [2:0] MODE_STALK  = 3'd0;
   localparam logic [2:0] MODE_KNOB   = 3'd1;
   localparam logic [2:0] MODE_FRAME  = 3'd2;
   localparam logic [2:0] MODE_CTRL   = 3'd3;
   localparam logic [2:0] MODE_STATUS = 3'd4;

   // turn command codes
   localparam logic [1:0] TURN_OFF    = 2'd0;
   localparam logic [1:0] TURN_LEFT   = 2'd1;
   localparam logic [1:0] TURN_RIGHT  = 2'd2;
   localparam logic [1:0] TURN_HAZARD = 2'd3;

   // winning lamp codes
   localparam logic [1:0] LAMP_NONE = 2'd0;
   localparam logic [1:0] LAMP_POS  = 2'd1;
   localparam logic [1:0] LAMP_TURN = 2'd2;

   // turn status codes in the status frame
   localparam logic [1:0] TSTAT_IDLE = 2'd0;
   localparam logic [1:0] TSTAT_LIT  = 2'd1;
   localparam logic [1:0] TSTAT_DARK = 2'd2;

   // configuration register indexes and reset values
   localparam logic CSR_FRAME_ID    = 1'b0;
   localparam logic CSR_HALF_PERIOD = 1'b1;
   localparam int   CSR_DATA_W      = 29;
   localparam logic [28:0] FRAME_ID_RESET    = 29'd256;
   localparam logic [7:0]  HALF_PERIOD_RESET = 8'd25;

   typedef struct packed {
      logic [2:0]  mode;
      logic [28:0] frame_id;
      logic [7:0]  frame_byte0;
   } req_type;

   typedef struct packed {
      logic       turn_lamp_on;
      logic       pos_lamp_on;
      logic [1:0] lead_lamp;
      logic       status_valid;
      logic [4:0] status_byte0;
      logic [3:0] status_byte1;
   } rsp_type;

   typedef struct packed {
      logic [1:0] turn_command;
      logic       position_command;
      logic [1:0] last_frame_turn;
      logic       last_frame_position;
      logic       last_frame_seen;
      logic [7:0] blink_count;
      logic       flash_phase;
      logic [1:0] winning_lamp;
      logic       turn_drive;
      logic       position_drive;
      logic [3:0] rolling_count;
   } state_type;

endpackage

FILE: src/lamp_priority_flasher.sv
// top level of the lamp priority flasher
//
// Lamp controller for one vehicle side, driven by one event per transaction:
// stalk key, knob key, bus frame, control tick or status tick. Every accepted
// transaction gives exactly one result transaction, registered in the output
// register or skid entry; a new transaction is accepted in every cycle while
// req_stall is low. The state update is a single pass of logic between the
// state registers and the result register. The result side has an output
// register plus one skid entry, so req_stall comes from a register and rises
// only once the skid entry holds a result that the receiver has not taken.
// Configuration writes (frame id, blink half period) take effect at the clock edge of the write.
`timescale 1ns / 1ps
module lamp_priority_flasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpf_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [28:0]      csr_wdata
);
   import lpf_pkg::*;

   logic [28:0] frame_id_ff;
   logic [7:0]  half_period_ff;
   state_type   state_ff;
   state_type   state_in;
   rsp_type     step_rsp;
   logic        out_valid_ff;
   rsp_type     out_data_ff;
   logic        skid_valid_ff;
   rsp_type     skid_data_ff;
   logic        req_take;
   logic        out_take;

   assign req_take  = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff    <= FRAME_ID_RESET;
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_ID:    frame_id_ff    <= csr_wdata;
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata[7:0];
            default:         frame_id_ff    <= frame_id_ff;
         endcase
      end
   end

   lpf_step u_step (
      .cur_state       (state_ff),
      .req             (req_data),
      .cfg_frame_id    (frame_id_ff),
      .cfg_half_period (half_period_ff),
      .nxt_state       (state_in),
      .result          (step_rsp)
   );

   // lamp state advances on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (out_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_take) begin
            if (out_valid_ff && rsp_stall) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payload moves without reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (req_take) begin
         if (out_valid_ff && rsp_stall) begin
            skid_data_ff <= step_rsp;
         end else begin
            out_data_ff <= step_rsp;
         end
      end
   end

endmodule

FILE: src/lpf_step.sv
// next-state and result logic for one event of the lamp flasher
`timescale 1ns / 1ps
module lpf_step (
   input  lpf_pkg::state_type cur_state,
   input  lpf_pkg::req_type   req,
   input  logic [28:0]        cfg_frame_id,
   input  logic [7:0]         cfg_half_period,
   output lpf_pkg::state_type nxt_state,
   output lpf_pkg::rsp_type   result
);
   import lpf_pkg::*;

   logic       turn_active;
   logic [7:0] count_inc;
   logic [1:0] frame_turn;
   logic       frame_pos;
   logic       frame_new;
   logic [1:0] turn_status;

   assign turn_active = (cur_state.turn_command == TURN_LEFT) ||
                        (cur_state.turn_command == TURN_HAZARD);
   assign count_inc   = cur_state.blink_count + 8'd1;
   assign frame_turn  = req.frame_byte0[1:0];
   assign frame_pos   = req.frame_byte0[2];
   assign frame_new   = !cur_state.last_frame_seen ||
                        (frame_turn != cur_state.last_frame_turn) ||
                        (frame_pos != cur_state.last_frame_position);

   // turn status as seen at the last control tick
   always_comb begin
      if (cur_state.winning_lamp == LAMP_TURN) begin
         turn_status = cur_state.turn_drive ? TSTAT_LIT : TSTAT_DARK;
      end else begin
         turn_status = TSTAT_IDLE;
      end
   end

   // state update per event kind
   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      unique case (req.mode)
         MODE_STALK: begin
            unique case (cur_state.turn_command)
               TURN_OFF:  nxt_state.turn_command = TURN_LEFT;
               TURN_LEFT: nxt_state.turn_command = TURN_HAZARD;
               default:   nxt_state.turn_command = TURN_OFF;
            endcase
         end
         MODE_KNOB: begin
            nxt_state.position_command = !cur_state.position_command;
         end
         MODE_FRAME: begin
            if ((req.frame_id == cfg_frame_id) && frame_new) begin
               nxt_state.last_frame_seen     = 1'b1;
               nxt_state.last_frame_turn     = frame_turn;
               nxt_state.last_frame_position = frame_pos;
               nxt_state.turn_command        = frame_turn;
               nxt_state.position_command    = frame_pos;
            end
         end
         MODE_CTRL: begin
            if (turn_active) begin
               // turn wins: blink and force the position lamp dark
               nxt_state.winning_lamp   = LAMP_TURN;
               nxt_state.position_drive = 1'b0;
               if (count_inc >= cfg_half_period) begin
                  nxt_state.blink_count = '0;
                  nxt_state.flash_phase = !cur_state.flash_phase;
               end else begin
                  nxt_state.blink_count = count_inc;
               end
               nxt_state.turn_drive = nxt_state.flash_phase;
            end else begin
               nxt_state.blink_count    = '0;
               nxt_state.flash_phase    = 1'b0;
               nxt_state.turn_drive     = 1'b0;
               nxt_state.position_drive = cur_state.position_command;
               nxt_state.winning_lamp   = cur_state.position_command ? LAMP_POS : LAMP_NONE;
            end
         end
         MODE_STATUS: begin
            result.status_valid     = 1'b1;
            result.status_byte0     = {cur_state.winning_lamp, cur_state.position_drive,
                                       turn_status};
            result.status_byte1     = cur_state.rolling_count;
            nxt_state.rolling_count = cur_state.rolling_count + 4'd1;
         end
         default: begin
            // unused event kinds leave the state alone
         end
      endcase
      result.turn_lamp_on = nxt_state.turn_drive;
      result.pos_lamp_on  = nxt_state.position_drive;
      result.lead_lamp    = nxt_state.winning_lamp;
   end

endmodule

FILE: src/lpf_checker.sv
// port-level checks of the lamp priority flasher, bound to the top level
`timescale 1ns / 1ps
`include "lamp_priority_flasher_assert.svh"
module lpf_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lpf_pkg::rsp_type rsp_data
);
   import lpf_pkg::*;

   // a stalled result transaction holds
   `LPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // no status fields outside a status transaction
   `LPF_ASSERT_NOW(a_status_quiet, clock, reset, rsp_valid && !rsp_data.status_valid, rsp_data.status_byte0 == 5'd0 && rsp_data.status_byte1 == 4'd0)

   // turn lamp only lit while turn wins
   `LPF_ASSERT_NOW(a_turn_owner, clock, reset, rsp_valid && rsp_data.lead_lamp != LAMP_TURN, !rsp_data.turn_lamp_on)

   // position lamp lit exactly when it wins
   `LPF_ASSERT_NOW(a_pos_owner, clock, reset, rsp_valid, rsp_data.pos_lamp_on == (rsp_data.lead_lamp == LAMP_POS))

   // status frame agrees with the lamp drives it reports
   `LPF_ASSERT_NOW(a_status_match, clock, reset, rsp_valid && rsp_data.status_valid, rsp_data.status_byte0[4:3] == rsp_data.lead_lamp && rsp_data.status_byte0[2] == rsp_data.pos_lamp_on)

endmodule

bind lamp_priority_flasher lpf_checker u_lpf_checker (.*);

FILE: tb/sv/lamp_priority_flasher_test.sv
// self-checking testbench for the lamp priority flasher
`timescale 1ns / 1ps
module lamp_priority_flasher_test;
   import lpf_pkg::*;

   // clock, reset and block ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_FRAME_ID;
   logic [28:0] csr_wdata = '0;

   // lamp controller state as the predictor tracks it
   typedef struct packed {
      logic [1:0] turn_sel;
      logic       pos_cmd;
      logic [1:0] frame_turn;
      logic       frame_pos;
      logic       frame_seen;
      logic [7:0] blink_count;
      logic       flash_phase;
      logic [1:0] winner;
      logic       turn_drive;
      logic       pos_drive;
      logic [3:0] rolling;
   } lamp_model_type;

   lamp_model_type lamp;
   logic [28:0] cfg_frame_id;
   logic [7:0]  cfg_half_period;

   req_type pending_events[$];
   rsp_type predicted_results[$];

   int events_accepted = 0;
   int results_seen    = 0;
   int mismatches      = 0;
   int reg_writes      = 0;
   int long_holds      = 0;
   int drain_pauses    = 0;
   int gap_left        = 0;
   int burst_left      = 1;
   int hold_left       = 0;
   int pattern_left    = 0;
   int stall_pct       = 0;
   logic draining      = 1'b0;

   lamp_priority_flasher DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // random filler for fields an event does not use
   function automatic logic [28:0] any_id();
      return 29'($urandom);
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom);
   endfunction

   // apply one event to the tracked state and return the lamp result it gives
   function automatic rsp_type predict_lamps(req_type ev);
      rsp_type    res;
      logic [1:0] new_turn;
      logic       new_pos;
      logic [1:0] turn_status;
      res = '0;
      new_turn = ev.frame_byte0[1:0];
      new_pos = ev.frame_byte0[2];
      turn_status = TSTAT_IDLE;
      case (ev.mode)
         MODE_STALK: begin
            // off -> left -> hazard -> off, right also goes to off
            if (lamp.turn_sel == TURN_OFF) lamp.turn_sel = TURN_LEFT;
            else if (lamp.turn_sel == TURN_LEFT) lamp.turn_sel = TURN_HAZARD;
            else lamp.turn_sel = TURN_OFF;
         end
         MODE_KNOB: begin
            lamp.pos_cmd = ~lamp.pos_cmd;
         end
         MODE_FRAME: begin
            // matching id only, and only when the commands changed since the last frame
            if (ev.frame_id == cfg_frame_id &&
                (!lamp.frame_seen || new_turn != lamp.frame_turn ||
                 new_pos != lamp.frame_pos)) begin
               lamp.frame_seen = 1'b1;
               lamp.frame_turn = new_turn;
               lamp.frame_pos  = new_pos;
               lamp.turn_sel   = new_turn;
               lamp.pos_cmd    = new_pos;
            end
         end
         MODE_CTRL: begin
            // left or hazard blinks the turn lamp and darkens the position lamp
            if (lamp.turn_sel == TURN_LEFT || lamp.turn_sel == TURN_HAZARD) begin
               lamp.winner = LAMP_TURN;
               lamp.pos_drive = 1'b0;
               lamp.blink_count = lamp.blink_count + 8'd1;
               if (lamp.blink_count >= cfg_half_period) begin
                  lamp.blink_count = '0;
                  lamp.flash_phase = ~lamp.flash_phase;
               end
               lamp.turn_drive = lamp.flash_phase;
            end else begin
               lamp.blink_count = '0;
               lamp.flash_phase = 1'b0;
               lamp.turn_drive = 1'b0;
               lamp.winner = lamp.pos_cmd ? LAMP_POS : LAMP_NONE;
               lamp.pos_drive = lamp.pos_cmd;
            end
         end
         MODE_STATUS: begin
            if (lamp.winner == LAMP_TURN) turn_status = lamp.turn_drive ? TSTAT_LIT : TSTAT_DARK;
            res.status_valid = 1'b1;
            res.status_byte0 = {lamp.winner, lamp.pos_drive, turn_status};
            res.status_byte1 = lamp.rolling;
            lamp.rolling = lamp.rolling + 4'd1;
         end
         default: begin
         end
      endcase
      res.turn_lamp_on = lamp.turn_drive;
      res.pos_lamp_on = lamp.pos_drive;
      res.lead_lamp = lamp.winner;
      return res;
   endfunction

   // sender: bursts of transactions with random gaps and occasional drain pauses
   always @(posedge clock) begin : event_driver
      req_type next_event;
      logic    next_valid;
      next_event = req_data;
      next_valid = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_results.push_back(predict_lamps(req_data));
            events_accepted++;
         end
         if (req_valid && req_stall) begin
            next_valid = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (draining) begin
            if (predicted_results.size() == 0) draining = 1'b0;
         end else if (pending_events.size() > 0) begin
            next_event = pending_events.pop_front();
            next_valid = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               if ($urandom_range(0, 29) == 0) begin
                  draining = 1'b1;
                  drain_pauses++;
               end
            end
         end
         req_valid <= next_valid;
         req_data  <= next_event;
      end
   end

   // receiver: stall pattern of its own plus long hold-offs
   always @(posedge clock) begin : result_sink
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if ((long_holds == 0 && req_valid && pending_events.size() > 8) ||
                   $urandom_range(0, 599) == 0) begin
         hold_left = $urandom_range(40, 80);
         long_holds++;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left > 0) begin
            pattern_left--;
         end else begin
            pattern_left = $urandom_range(10, 60);
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 20;
               3:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s wrong, expected %h, got %h", $time, field, want, got);
      end
   endtask

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (predicted_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result %h arrived with nothing predicted", $time, rsp_data);
         end else begin
            want = predicted_results.pop_front();
            check_field("turn_lamp_on", 8'(want.turn_lamp_on), 8'(rsp_data.turn_lamp_on));
            check_field("pos_lamp_on", 8'(want.pos_lamp_on), 8'(rsp_data.pos_lamp_on));
            check_field("lead_lamp", 8'(want.lead_lamp), 8'(rsp_data.lead_lamp));
            check_field("status_valid", 8'(want.status_valid), 8'(rsp_data.status_valid));
            check_field("status_byte0", 8'(want.status_byte0), 8'(rsp_data.status_byte0));
            check_field("status_byte1", 8'(want.status_byte1), 8'(rsp_data.status_byte1));
         end
      end
   end

   task automatic queue_event(logic [2:0] mode, logic [28:0] id, logic [7:0] data);
      req_type ev;
      ev.mode = mode;
      ev.frame_id = id;
      ev.frame_byte0 = data;
      pending_events.push_back(ev);
   endtask

   // mostly real lamp traffic, some foreign frames and unused event kinds
   task automatic queue_random(int count);
      req_type ev;
      int      pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         ev.frame_id = any_id();
         ev.frame_byte0 = any_byte();
         if (pick < 8) begin
            ev.mode = MODE_STALK;
         end else if (pick < 14) begin
            ev.mode = MODE_KNOB;
         end else if (pick < 34) begin
            ev.mode = MODE_FRAME;
            if ($urandom_range(0, 5) != 0) ev.frame_id = cfg_frame_id;
         end else if (pick < 72) begin
            ev.mode = MODE_CTRL;
         end else if (pick < 88) begin
            ev.mode = MODE_STATUS;
         end else if (pick < 94) begin
            ev.mode = MODE_FRAME;
         end else begin
            ev.mode = 3'($urandom_range(5, 7));
         end
         pending_events.push_back(ev);
      end
   endtask

   // block idle: nothing queued, nothing offered, nothing outstanding
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [28:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      if (idx == CSR_FRAME_ID) cfg_frame_id = value;
      else cfg_half_period = value[7:0];
      reg_writes++;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // run sequence
   initial begin : stimulus
      logic [28:0] id_pick;
      logic [7:0]  half_pick;
      lamp = '0;
      cfg_frame_id = FRAME_ID_RESET;
      cfg_half_period = HALF_PERIOD_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers, key cycling, first and repeated frames
      queue_event(MODE_STATUS, any_id(), any_byte());
      queue_event(3'd5, any_id(), any_byte());
      queue_event(3'd7, 29'h1FFFFFFF, 8'hFF);
      queue_event(MODE_KNOB, any_id(), any_byte());
      queue_event(MODE_CTRL, any_id(), any_byte());
      queue_event(MODE_STATUS, any_id(), any_byte());
      queue_event(MODE_STALK, any_id(), any_byte());
      repeat (2) queue_event(MODE_CTRL, any_id(), any_byte());
      queue_event(MODE_STATUS, any_id(), any_byte());
      queue_event(MODE_STALK, any_id(), any_byte());
      queue_event(MODE_STALK, any_id(), any_byte());
      queue_event(MODE_FRAME, FRAME_ID_RESET - 29'd1, {4'h0, 1'b0, 1'b1, TURN_LEFT});
      queue_event(MODE_FRAME, FRAME_ID_RESET, {4'hF, 1'b0, 1'b1, TURN_LEFT});
      queue_event(MODE_CTRL, any_id(), any_byte());
      queue_event(MODE_STALK, any_id(), any_byte());
      queue_event(MODE_FRAME, FRAME_ID_RESET, {4'h3, 1'b0, 1'b1, TURN_LEFT});
      queue_event(MODE_CTRL, any_id(), any_byte());
      queue_event(MODE_FRAME, FRAME_ID_RESET, {4'hA, 1'b1, 1'b1, TURN_RIGHT});
      queue_event(MODE_CTRL, any_id(), any_byte());
      queue_event(MODE_STATUS, any_id(), any_byte());
      queue_event(MODE_STALK, any_id(), any_byte());
      queue_event(3'd6, any_id(), any_byte());
      wait_quiet();

      // widest id and a zero half period, which toggles on every tick
      write_reg(CSR_FRAME_ID, 29'h1FFFFFFF);
      write_reg(CSR_HALF_PERIOD, 29'd0);
      queue_event(MODE_FRAME, 29'h1FFFFFFF, {4'h0, 1'b1, 1'b1, TURN_HAZARD});
      repeat (3) queue_event(MODE_CTRL, any_id(), any_byte());
      queue_event(MODE_FRAME, 29'd0, 8'h00);
      queue_event(MODE_STATUS, any_id(), any_byte());
      wait_quiet();

      // longest half period, then lowered below the running count
      write_reg(CSR_FRAME_ID, 29'd0);
      write_reg(CSR_HALF_PERIOD, 29'd255);
      queue_event(MODE_FRAME, 29'd0, {4'h5, 1'b0, 1'b0, TURN_LEFT});
      repeat (8) queue_event(MODE_CTRL, any_id(), any_byte());
      wait_quiet();
      write_reg(CSR_HALF_PERIOD, 29'd3);
      repeat (2) queue_event(MODE_CTRL, any_id(), any_byte());
      queue_event(MODE_STATUS, any_id(), any_byte());
      wait_quiet();

      // random phases, each with its own register setting
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       begin id_pick = any_id(); half_pick = 8'd1; end
            1:       begin id_pick = 29'd0; half_pick = 8'($urandom_range(2, 6)); end
            2:       begin id_pick = 29'h1FFFFFFF; half_pick = 8'd255; end
            3:       begin id_pick = any_id(); half_pick = 8'($urandom_range(1, 12)); end
            default: begin id_pick = FRAME_ID_RESET; half_pick = 8'd2; end
         endcase
         write_reg(CSR_FRAME_ID, id_pick);
         write_reg(CSR_HALF_PERIOD, {21'd0, half_pick});
         queue_random(85);
         wait_quiet();
      end

      // let any stray result show up before the verdict
      repeat (8) @(negedge clock);
      $display("covered %0d events and %0d lamp results over %0d register writes",
               events_accepted, results_seen, reg_writes);
      $display("receiver hold-offs: %0d, sender drain pauses: %0d", long_holds, drain_pauses);
      if (mismatches == 0 && predicted_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #400000;
      $display("timeout with %0d results still outstanding", predicted_results.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
